/* design/bpse_pkg.sv */
// shared constants, types and codes for the byte pair stream expander
`default_nettype none

package bpse_pkg;

   localparam int TABLE_SIZE    = 256;
   localparam int MAX_EXPANSION = 64;
   localparam int STACK_DEPTH   = 64;

   // names are full bytes, so the pair store always spans every byte value
   localparam int NAME_COUNT = 256;
   localparam int PAIR_W     = 16;

   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int EMIT_W  = $clog2(MAX_EXPANSION + 1);
   localparam int CHECK_W = ((SP_W > EMIT_W) ? SP_W : EMIT_W) + 1;

   localparam logic [7:0] MAGIC_B = 8'h42;
   localparam logic [7:0] MAGIC_P = 8'h50;
   localparam logic [7:0] MAGIC_E = 8'h45;

   typedef enum logic [1:0] {
      STATUS_DATA      = 2'd0,
      STATUS_BAD_MAGIC = 2'd1,
      STATUS_TOO_LONG  = 2'd2
   } status_type;

   // header parser to expansion engine
   typedef struct packed {
      logic              map_clear;
      logic              pair_we;
      logic [7:0]        pair_name;
      logic [PAIR_W-1:0] pair_data;
      logic              expand_go;
      logic              bad_magic;
   } hdr_cmd_type;

endpackage : bpse_pkg

`default_nettype wire

/* design/bpse_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module bpse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : bpse_ram

`default_nettype wire

/* design/bpse_hdr.sv */
// stream header parser: magic check, table count and pair entries
`default_nettype none

module bpse_hdr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          in_byte,
   input  wire logic                start_of_stream,
   output bpse_pkg::hdr_cmd_type    cmd
);
   import bpse_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC0  = 3'd0,
      PH_MAGIC1  = 3'd1,
      PH_MAGIC2  = 3'd2,
      PH_COUNT   = 3'd3,
      PH_ENTRIES = 3'd4,
      PH_DATA    = 3'd5,
      PH_FAILED  = 3'd6
   } phase_type;

   phase_type  phase_ff, phase_in, eff_phase;
   logic [7:0] entries_left_ff, entries_left_in;
   logic [1:0] pos_ff, pos_in;
   logic [7:0] name_ff, name_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] want;
   logic [8:0] count_sat;

   always_comb begin
      eff_phase       = start_of_stream ? PH_MAGIC0 : phase_ff;
      phase_in        = phase_ff;
      entries_left_in = start_of_stream ? 8'd0 : entries_left_ff;
      pos_in          = start_of_stream ? 2'd0 : pos_ff;
      name_in         = name_ff;
      first_in        = first_ff;
      want            = MAGIC_B;
      count_sat       = {1'b0, in_byte};
      if (count_sat > 9'(TABLE_SIZE)) begin
         count_sat = 9'(TABLE_SIZE);
      end

      cmd           = '0;
      cmd.map_clear = accept && start_of_stream;
      cmd.pair_name = name_ff;
      cmd.pair_data = {first_ff, in_byte};

      unique case (eff_phase)
         PH_MAGIC0, PH_MAGIC1, PH_MAGIC2: begin
            if (eff_phase == PH_MAGIC1) begin
               want = MAGIC_P;
            end else if (eff_phase == PH_MAGIC2) begin
               want = MAGIC_E;
            end
            if (in_byte != want) begin
               cmd.bad_magic = accept;
               phase_in      = PH_FAILED;
            end else if (eff_phase == PH_MAGIC0) begin
               phase_in = PH_MAGIC1;
            end else if (eff_phase == PH_MAGIC1) begin
               phase_in = PH_MAGIC2;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            entries_left_in = count_sat[7:0];
            pos_in          = 2'd0;
            phase_in        = (count_sat != 9'd0) ? PH_ENTRIES : PH_DATA;
         end
         PH_ENTRIES: begin
            if (pos_ff == 2'd0) begin
               name_in = in_byte;
               pos_in  = 2'd1;
            end else if (pos_ff == 2'd1) begin
               first_in = in_byte;
               pos_in   = 2'd2;
            end else begin
               cmd.pair_we     = accept;
               pos_in          = 2'd0;
               entries_left_in = entries_left_ff - 8'd1;
               if (entries_left_ff == 8'd1) begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            cmd.expand_go = accept;
         end
         PH_FAILED: begin
         end
         default: begin
            phase_in = PH_FAILED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_MAGIC0;
         entries_left_ff <= 8'd0;
         pos_ff          <= 2'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         entries_left_ff <= entries_left_in;
         pos_ff          <= pos_in;
      end
      if (accept) begin
         name_ff  <= name_in;
         first_ff <= first_in;
      end
   end

endmodule : bpse_hdr

`default_nettype wire

/* design/bpse_engine.sv */
// expansion engine: defined map, pair store, stack memory and output register
`default_nettype none

module bpse_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bpse_pkg::hdr_cmd_type cmd,
   input  wire logic [7:0]            in_byte,
   output logic                       busy,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic [1:0]                 rsp_status
);
   import bpse_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EVAL = 2'd1,
      ST_PAIR = 2'd2,
      ST_POP  = 2'd3
   } state_type;

   state_type           state_ff, state_in;
   logic [NAME_COUNT-1:0] defined_ff;
   logic [7:0]          cur_ff, cur_in;
   logic [SP_W-1:0]     sp_ff, sp_in, sp_dec;
   logic [EMIT_W-1:0]   emitted_ff, emitted_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;
   status_type          status_ff, status_in;

   logic                out_free;
   logic                too_long;
   logic [CHECK_W-1:0]  depth_need, fill_need;
   logic [PAIR_W-1:0]   pair_rd;
   logic [7:0]          stk_rd;
   logic                stk_we;

   bpse_ram #(.WIDTH(PAIR_W), .DEPTH(NAME_COUNT)) u_pair_ram (
      .clock   (clock),
      .wr_en   (cmd.pair_we),
      .wr_addr (cmd.pair_name),
      .wr_data (cmd.pair_data),
      .rd_addr (cur_ff),
      .rd_data (pair_rd)
   );

   bpse_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[STK_AW-1:0]),
      .wr_data (pair_rd[7:0]),
      .rd_addr (sp_dec[STK_AW-1:0]),
      .rd_data (stk_rd)
   );

   always_comb begin
      out_free   = !valid_ff || !rsp_stall;
      sp_dec     = sp_ff - SP_W'(1);
      depth_need = CHECK_W'(sp_ff) + CHECK_W'(2);
      fill_need  = CHECK_W'(emitted_ff) + CHECK_W'(sp_ff) + CHECK_W'(2);
      too_long   = (depth_need > CHECK_W'(STACK_DEPTH)) ||
                   (fill_need > CHECK_W'(MAX_EXPANSION));

      state_in   = state_ff;
      cur_in     = cur_ff;
      sp_in      = sp_ff;
      emitted_in = emitted_ff;
      stk_we     = 1'b0;
      valid_in   = valid_ff && rsp_stall;
      byte_in    = byte_ff;
      last_in    = last_ff;
      status_in  = status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.bad_magic) begin
               valid_in  = 1'b1;
               byte_in   = 8'd0;
               last_in   = 1'b1;
               status_in = STATUS_BAD_MAGIC;
            end
            if (cmd.expand_go) begin
               cur_in     = in_byte;
               sp_in      = '0;
               emitted_in = '0;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (defined_ff[cur_ff]) begin
               if (too_long) begin
                  if (out_free) begin
                     valid_in  = 1'b1;
                     byte_in   = 8'd0;
                     last_in   = 1'b1;
                     status_in = STATUS_TOO_LONG;
                     state_in  = ST_IDLE;
                  end
               end else begin
                  state_in = ST_PAIR;
               end
            end else if (out_free) begin
               valid_in   = 1'b1;
               byte_in    = cur_ff;
               last_in    = (sp_ff == '0);
               status_in  = STATUS_DATA;
               emitted_in = emitted_ff + EMIT_W'(1);
               if (sp_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  sp_in    = sp_dec;
                  state_in = ST_POP;
               end
            end
         end
         ST_PAIR: begin
            // first byte expands next, second waits on the stack
            cur_in   = pair_rd[15:8];
            stk_we   = 1'b1;
            sp_in    = sp_ff + SP_W'(1);
            state_in = ST_EVAL;
         end
         ST_POP: begin
            cur_in   = stk_rd;
            state_in = ST_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         sp_ff      <= '0;
         emitted_ff <= '0;
         defined_ff <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         sp_ff      <= sp_in;
         emitted_ff <= emitted_in;
         if (cmd.map_clear) begin
            defined_ff <= '0;
         end else if (cmd.pair_we) begin
            defined_ff[cmd.pair_name] <= 1'b1;
         end
      end
      cur_ff    <= cur_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign busy            = (state_ff != ST_IDLE) || (valid_ff && rsp_stall);
   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_status      = status_ff;

endmodule : bpse_engine

`default_nettype wire

/* design/byte_pair_stream_expander.sv */
// top level of the byte pair stream expander
`default_nettype none

// byte pair stream expander
// input channel (req_): one byte of a compressed file per item; start_of_stream
//   restarts the parse with that byte as the first magic byte and clears
//   the table of defined pair names
// result channel (rsp_): one decompressed byte per item, last_of_run marks the
//   final result caused by an input byte, status flags bad magic and overlong
//   expansions (out_byte is 0 on those)
// header bytes (magic, count, entries) give no result, except a bad magic byte,
//   whose error item shows in the cycle after accept
// a data byte expands through the pair store with a stack held in memory:
//   each substitution is a pair store read, then a push, and each result an
//   emit, then a stack pop, the last one only the emit; the next item is
//   taken only once the expansion is done
// the first result is registered from the evaluate state that follows accept
//   and the substitutions ahead of it; the input is stalled for the whole expansion
// a stalled result holds in the output register; the engine goes on
//   substituting but waits at its next result, and the input waits with it;
//   header bytes are still taken while the result register can drain
// reset (synchronous, active high) clears the parse, the defined map and the
//   engine; the pair store and stack need no clearing

module byte_pair_stream_expander (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_start_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run,
   output logic [1:0]      rsp_status
);
   import bpse_pkg::*;

   hdr_cmd_type cmd;
   logic        req_accept;
   logic        engine_busy;

   // the engine is busy while expanding or while its result cannot drain
   assign req_stall  = engine_busy;
   assign req_accept = req_valid && !req_stall;

   // header parse: decides what each accepted byte means
   bpse_hdr u_hdr (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .in_byte         (req_in_byte),
      .start_of_stream (req_start_of_stream),
      .cmd             (cmd)
   );

   // expansion: pair store, stack memory and result register
   bpse_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_byte         (req_in_byte),
      .busy            (engine_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status)
   );

endmodule : byte_pair_stream_expander

`default_nettype wire

/* design/bpse_checker.sv */
// port level checks for the byte pair stream expander
`default_nettype none

module bpse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_in_byte,
   input wire logic       req_start_of_stream,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_of_run,
   input wire logic [1:0] rsp_status
);
   import bpse_pkg::*;

   // error items close their run and carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DATA |-> rsp_last_of_run && rsp_out_byte == 8'd0)
      else $error("error item not last or nonzero byte");

   // a fresh bad magic item comes right after an accepted input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_MAGIC && !$past(rsp_valid && rsp_stall)
      |-> $past(req_valid && !req_stall))
      else $error("bad magic item without an accepted input");

   // a blocked result also blocks the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result is blocked");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status))
      else $error("stalled result changed");

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   logic unused_in;
   assign unused_in = ^{req_in_byte, req_start_of_stream};

endmodule : bpse_checker

bind byte_pair_stream_expander bpse_checker u_bpse_checker (.*);

`default_nettype wire
